// ----- src/ctbd_pkg.sv -----
`default_nettype none

package ctbd_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int THR_BITS    = 16;
    localparam int SUM_BITS    = ((COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS) + 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(2500);

    typedef enum logic [0:0] {
        CFG_KEY_THRESHOLD  = 1'b0,
        CFG_SECOND_ENABLED = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_INIT          = 3'd0,
        PH_WAIT_PRESS    = 3'd1,
        PH_PRESS_CHECK   = 3'd2,
        PH_WAIT_RELEASE  = 3'd3,
        PH_RELEASE_CHECK = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase                  phase;
        logic [COUNT_BITS-1:0]   baseline;
    } t_btn_state;

    typedef struct packed {
        t_btn_state              next;
        logic                    press;
        logic                    release_ev;
    } t_btn_result;

endpackage

`default_nettype wire

// ----- src/ctbd_update.sv -----
`default_nettype none

module ctbd_update (
    input  wire ctbd_pkg::t_btn_state                 i_cur,
    input  wire logic [ctbd_pkg::COUNT_BITS-1:0]      i_count,
    input  wire logic [ctbd_pkg::THR_BITS-1:0]        i_threshold,
    output ctbd_pkg::t_btn_result                     o_result
);
    import ctbd_pkg::*;

    logic [COUNT_BITS-1:0] base;
    logic [SUM_BITS-1:0]   base_x;
    logic [SUM_BITS-1:0]   cnt_x;
    logic [SUM_BITS-1:0]   thr_x;

    logic                  p_lt;
    logic [SUM_BITS-1:0]   p_lim;
    logic [COUNT_BITS-1:0] p_clamp;
    logic [COUNT_BITS-1:0] p_base;
    logic [COUNT_BITS-1:0] p_delta;
    logic                  p_hit;

    logic                  r_gt;
    logic [SUM_BITS-1:0]   r_lim;
    logic [COUNT_BITS-1:0] r_clamp;
    logic [COUNT_BITS-1:0] r_base;
    logic [COUNT_BITS-1:0] r_delta;
    logic                  r_hit;

    t_phase                n_phase;

    function automatic logic [COUNT_BITS-1:0] drift(input logic [COUNT_BITS-1:0] x);
        drift = (x == '0) ? x : x - COUNT_BITS'(1);
    endfunction

    assign base   = i_cur.baseline;
    assign base_x = SUM_BITS'(base);
    assign cnt_x  = SUM_BITS'(i_count);
    assign thr_x  = SUM_BITS'(i_threshold);

    // falling side: clamp count to baseline + threshold
    assign p_lt    = base < i_count;
    assign p_lim   = base_x + thr_x;
    assign p_clamp = (cnt_x > p_lim) ? p_lim[COUNT_BITS-1:0] : i_count;
    assign p_base  = p_lt ? ((base >> 1) + (p_clamp >> 1)) : base;
    assign p_delta = base - i_count;
    assign p_hit   = !p_lt && (SUM_BITS'(p_delta) > thr_x);

    // rising side: clamp count to baseline - threshold
    assign r_gt    = base > i_count;
    assign r_lim   = thr_x + cnt_x;
    assign r_clamp = (base_x > r_lim) ? COUNT_BITS'(base_x - thr_x) : i_count;
    assign r_base  = r_gt ? ((base >> 1) + (r_clamp >> 1)) : base;
    assign r_delta = i_count - base;
    assign r_hit   = !r_gt && (SUM_BITS'(r_delta) > thr_x);

    always_comb begin
        case (i_cur.phase)
            PH_WAIT_PRESS:    n_phase = (base != '0 && p_hit) ? PH_PRESS_CHECK : PH_WAIT_PRESS;
            PH_PRESS_CHECK:   n_phase = p_hit ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
            PH_WAIT_RELEASE:  n_phase = r_hit ? PH_RELEASE_CHECK : PH_WAIT_RELEASE;
            PH_RELEASE_CHECK: n_phase = r_hit ? PH_WAIT_PRESS : PH_WAIT_RELEASE;
            default:          n_phase = PH_WAIT_PRESS;
        endcase
    end

    always_comb begin
        o_result.next.phase = n_phase;
        o_result.press      = 1'b0;
        o_result.release_ev = 1'b0;
        case (i_cur.phase)
            PH_WAIT_PRESS: begin
                if (base == '0) begin
                    o_result.next.baseline = i_count;
                end else if (p_hit) begin
                    o_result.next.baseline = p_base;
                end else begin
                    o_result.next.baseline = drift(p_base);
                end
            end
            PH_PRESS_CHECK: begin
                o_result.next.baseline = p_base;
                o_result.press         = p_hit;
            end
            PH_WAIT_RELEASE: begin
                o_result.next.baseline = r_hit ? r_base : drift(r_base);
            end
            PH_RELEASE_CHECK: begin
                o_result.next.baseline = r_hit ? r_base : drift(r_base);
                o_result.release_ev    = r_hit;
            end
            default: begin
                o_result.next.baseline = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/cap_touch_button_detector_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_ready   i_sample_count
// out       out  o_out_valid / i_out_ready o_button_id, o_press_event, o_release_event,
//                                          o_baseline_level, o_detector_state
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled. A sample in the input
// register moves on to the result register once that register is free or being drained.
// The detector update runs between the two registers and writes the button state
// in the same cycle, so each sample sees the state that earlier samples left for its button.
// Reset is synchronous; it clears the valid flags and both buttons' state, sets the
// threshold to THR_RESET and disables the second button; no clearing pass.
// A stalled result holds the result register; the input register takes at most one
// more sample, then o_in_ready drops until the result transfer.

module cap_touch_button_detector_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [ctbd_pkg::COUNT_BITS-1:0]     i_sample_count,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_button_id,
    output logic                                     o_press_event,
    output logic                                     o_release_event,
    output logic [ctbd_pkg::COUNT_BITS-1:0]          o_baseline_level,
    output logic [2:0]                               o_detector_state,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [0:0]                          i_cfg_index,
    input  wire logic [ctbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ctbd_pkg::*;

    logic                  r_in_valid;
    logic [COUNT_BITS-1:0] r_in_count;
    logic                  r_out_valid;
    logic                  r_out_id;
    logic                  r_out_press;
    logic                  r_out_release;
    logic [COUNT_BITS-1:0] r_out_base;
    t_phase                r_out_phase;

    logic [THR_BITS-1:0]   r_threshold;
    logic                  r_second_en;
    t_btn_state            r_btn [2];
    logic                  r_served;

    logic                  adv;
    logic                  sel;
    logic                  n_served;
    t_btn_result           upd;
    logic                  cfg_wr;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign sel         = r_served & r_second_en;
    assign n_served    = !sel && r_second_en;

    ctbd_update u_update (
        .i_cur       (r_btn[sel]),
        .i_count     (r_in_count),
        .i_threshold (r_threshold),
        .o_result    (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_count <= i_sample_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out_id      <= sel;
            r_out_press   <= upd.press;
            r_out_release <= upd.release_ev;
            r_out_base    <= upd.next.baseline;
            r_out_phase   <= upd.next.phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_second_en <= 1'b0;
            r_served    <= 1'b0;
            r_btn[0]    <= '{phase: PH_INIT, baseline: '0};
            r_btn[1]    <= '{phase: PH_INIT, baseline: '0};
        end else begin
            if (adv) begin
                r_btn[sel] <= upd.next;
                r_served   <= n_served;
            end
            if (cfg_wr) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_KEY_THRESHOLD: r_threshold <= i_cfg_data[THR_BITS-1:0];
                    CFG_SECOND_ENABLED: begin
                        r_second_en <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_btn[1].phase <= PH_INIT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_button_id      = r_out_id;
    assign o_press_event    = r_out_press;
    assign o_release_event  = r_out_release;
    assign o_baseline_level = r_out_base;
    assign o_detector_state = r_out_phase;

    a_event_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_press_event && o_release_event))
        else $error("press and release reported together");

    a_press_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_press_event) |-> (o_detector_state == PH_WAIT_RELEASE))
        else $error("press without move to wait release");

    a_release_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_release_event) |-> (o_detector_state == PH_WAIT_PRESS))
        else $error("release without move to wait press");

    a_single_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_second_en) |=> (o_out_valid && !o_button_id))
        else $error("second button served while disabled");

endmodule

`default_nettype wire
